>>> hw/rtl/r2fft_pkg.sv
// shared types, codes and the twiddle generator for the radix-2 fft engine
// no dependencies; imported by every module of the block
package r2fft_pkg;

    // request kinds on the input channel (carried in tuser)
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // configuration register indexes
    localparam logic REG_INVERSE = 1'b0;
    localparam logic REG_SIZE    = 1'b1;

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_SW_RDI,
        ST_SW_RDR,
        ST_SW_WI,
        ST_SW_WR,
        ST_BF_RDQ,
        ST_BF_RDP,
        ST_BF_M0,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_VI,
        ST_BF_WP,
        ST_BF_WQ,
        ST_SC_RD,
        ST_SC_WR
    } r2fft_state_t;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI,
        MUL_IR
    } r2fft_mul_sel_t;

    typedef struct packed {
        logic           ld_x;
        logic           ld_u;
        logic           ld_pa;
        logic           ld_vr;
        logic           ld_vi;
        r2fft_mul_sel_t mul_sel;
        logic           inv;
    } r2fft_bfly_ctl_t;

    // unsigned quotient by restoring long division, evaluated at elaboration only
    function automatic longint unsigned udiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos or sin of 2*pi*t/2^log2m as a rounded q(frac) word, taylor series in q30
    function automatic longint twiddle_word(input int t, input int log2m, input int frac,
                                            input bit is_cos);
        longint unsigned m;
        longint unsigned tt;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          sum;
        longint          r;
        longint          lim;
        bit              upper;
        m     = 64'd1 << log2m;
        tt    = longint'(t);
        upper = tt > (m >> 2);
        u     = upper ? (m >> 1) - tt : tt;
        x     = (u * TWO_PI_Q30 + (m >> 1)) >> log2m;
        x2    = (x * x) >> 30;
        term  = is_cos ? Q30_ONE : x;
        sum   = longint'(term);
        for (int k = 1; k <= 12; k++) begin
            d    = is_cos ? longint'((2 * k - 1) * (2 * k)) : longint'((2 * k) * (2 * k + 1));
            term = udiv((term * x2) >> 30, d);
            if (k[0]) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        r   = (sum + (longint'(1) <<< (30 - frac - 1))) >>> (30 - frac);
        lim = (longint'(1) <<< frac) - 1;
        if (r > lim) r = lim;
        return (is_cos && upper) ? -r : r;
    endfunction

endpackage

>>> hw/rtl/r2fft_twiddle_rom.sv
// twiddle table: cos and sin over the first half turn, registered read
// depends on r2fft_pkg (twiddle_word)
module r2fft_twiddle_rom
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] t_idx,
    output logic signed [TWIDDLE_WIDTH-1:0] tw_cos,
    output logic signed [TWIDDLE_WIDTH-1:0] tw_sin
);
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int HALF = MAX_POINTS / 2;

    logic [TWIDDLE_WIDTH-1:0] cos_tab [HALF];
    logic [TWIDDLE_WIDTH-1:0] sin_tab [HALF];

    for (genvar g = 0; g < HALF; g++) begin : g_tab
        localparam longint CV = twiddle_word(g, AW, TWIDDLE_WIDTH - 1, 1'b1);
        localparam longint SV = twiddle_word(g, AW, TWIDDLE_WIDTH - 1, 1'b0);
        assign cos_tab[g] = CV[TWIDDLE_WIDTH-1:0];
        assign sin_tab[g] = SV[TWIDDLE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        tw_cos <= cos_tab[t_idx];
        tw_sin <= sin_tab[t_idx];
    end

endmodule

>>> hw/rtl/r2fft_bfly_unit.sv
// butterfly datapath: one shared multiplier, used four times per butterfly
// depends on r2fft_pkg (r2fft_bfly_ctl_t, r2fft_mul_sel_t)
module r2fft_bfly_unit
    import r2fft_pkg::*;
#(
    parameter int DATA_WIDTH    = 32,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic                            aclk,
    input  r2fft_bfly_ctl_t                 ctl,
    input  logic [2*DATA_WIDTH-1:0]         rd_data,
    input  logic signed [TWIDDLE_WIDTH-1:0] tw_cos,
    input  logic signed [TWIDDLE_WIDTH-1:0] tw_sin,
    output logic [2*DATA_WIDTH-1:0]         sum_data,
    output logic [2*DATA_WIDTH-1:0]         dif_data
);
    localparam int DW = DATA_WIDTH;
    localparam int TW = TWIDDLE_WIDTH;
    localparam int F  = TW - 1;
    localparam int PW = DW + TW;
    localparam logic signed [DW+1:0] MAXV = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] MINV = {3'b111, {(DW-1){1'b0}}};

    logic signed [DW-1:0] xr_reg, xi_reg, ur_reg, ui_reg, vr_reg, vi_reg;
    logic signed [DW:0]   prod_reg, pa_reg;
    logic signed [DW:0]   prod_next;
    logic signed [TW-1:0] wr, wi, mb;
    logic signed [DW-1:0] ma;
    logic signed [PW-1:0] full, rounded;

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+1:0] v);
        logic signed [DW+1:0] r;
        r = v;
        if (v > MAXV) r = MAXV;
        else if (v < MINV) r = MINV;
        return r[DW-1:0];
    endfunction

    assign wr = tw_cos;
    assign wi = ctl.inv ? -tw_sin : tw_sin;

    always_comb begin
        case (ctl.mul_sel)
            MUL_RR: begin ma = xr_reg; mb = wr; end
            MUL_II: begin ma = xi_reg; mb = wi; end
            MUL_RI: begin ma = xr_reg; mb = wi; end
            MUL_IR: begin ma = xi_reg; mb = wr; end
            default: begin ma = xr_reg; mb = wr; end
        endcase
    end

    // product rounded half up back to the data format
    assign full      = PW'(ma) * PW'(mb);
    assign rounded   = full + (PW'(1) <<< (F - 1));
    assign prod_next = rounded[PW-1:F];

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctl.ld_x) begin
            xr_reg <= rd_data[DW-1:0];
            xi_reg <= rd_data[2*DW-1:DW];
        end
        if (ctl.ld_u) begin
            ur_reg <= rd_data[DW-1:0];
            ui_reg <= rd_data[2*DW-1:DW];
        end
        if (ctl.ld_pa) pa_reg <= prod_reg;
        if (ctl.ld_vr) vr_reg <= sat_dw((DW+2)'(pa_reg) - (DW+2)'(prod_reg));
        if (ctl.ld_vi) vi_reg <= sat_dw((DW+2)'(pa_reg) + (DW+2)'(prod_reg));
    end

    assign sum_data = {sat_dw((DW+2)'(ui_reg) + (DW+2)'(vi_reg)),
                       sat_dw((DW+2)'(ur_reg) + (DW+2)'(vr_reg))};
    assign dif_data = {sat_dw((DW+2)'(ui_reg) - (DW+2)'(vi_reg)),
                       sat_dw((DW+2)'(ur_reg) - (DW+2)'(vr_reg))};

endmodule

>>> hw/rtl/radix2_fft_engine_top.sv
// top level of the radix-2 fft engine: sample store, sequencer, stream ports
// depends on r2fft_pkg, r2fft_twiddle_rom, r2fft_bfly_unit
//
// In-place radix-2 decimation-in-time complex FFT over 2^size_log2 points
// (size_log2 clamped to 1..log2(MAX_POINTS)). A load request (tuser 0) writes
// the next Q1.15 sample into the store; the load that fills the frame starts
// the transform with the registers of that moment. A read request (tuser 1)
// fetches the next bin into the result register and raises tlast on the last
// bin; a read with no finished frame returns nothing. Any load drops a frame
// under readout. The transform runs on one shared multiplier and a single-port
// read / single-port write sample memory, and the engine takes no requests
// while it runs: bit reversal, then the butterfly stages, each butterfly
// doing four multiplies on the shared unit plus memory reads and two writes,
// then for the inverse the 1/n scaling. Forward uses exp(+2*pi*i/len),
// inverse exp(-2*pi*i/len) then a rounding shift by log2(n). Config writes
// are accepted every cycle and should only be issued while the engine is idle.
module radix2_fft_engine_top
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int DATA_WIDTH    = 32,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_re [15:0], sample_im [31:16]
    input  logic        s_tuser,   // action
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // result_re [31:0], result_im [63:32], result_index [73:64]
    output logic        m_tlast,   // result_last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index, // 0 inverse_mode, 1 size_log2
    input  logic [3:0]  cfg_data
);
    localparam int DW  = DATA_WIDTH;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int LW  = $clog2(AW + 1);
    localparam int TIW = (AW > 1) ? AW - 1 : 1;
    localparam int XW  = (DW > 32) ? DW : 32;

    // config registers
    logic       inverse_reg;
    logic [3:0] size_reg;

    // sequencer state
    r2fft_state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] stage_reg, stage_next;
    logic [LW-1:0] frame_l_reg, frame_l_next;
    logic          inv_frame_reg, inv_frame_next;
    logic [AW-1:0] load_ptr_reg, load_ptr_next;
    logic [AW-1:0] read_ptr_reg, read_ptr_next;
    logic [AW-1:0] read_idx_reg, read_idx_next;
    logic          read_last_reg, read_last_next;
    logic          frame_ready_reg, frame_ready_next;

    // sample memory, real part low, imaginary part high
    logic [2*DW-1:0] mem [MAX_POINTS];
    logic [2*DW-1:0] rd_reg;
    logic [2*DW-1:0] hold_reg;
    logic            mem_we;
    logic [AW-1:0]   waddr, raddr;
    logic [2*DW-1:0] wdata;

    // result register
    logic        m_valid_reg;
    logic [31:0] out_re_reg, out_im_reg;
    logic [9:0]  out_idx_reg;
    logic        out_last_reg;

    // derived values
    logic [LW-1:0]   cur_l;
    logic [AW:0]     n_cur, n_frm;
    logic            s_acc, load_done, read_last;
    logic            cnt_last, half_last;
    logic [AW-1:0]   rev_full, rev, hm, bf_j, bf_p, bf_q, t_full;
    logic signed [15:0] smp_re, smp_im;
    logic signed [DW:0] rnd, sc_re, sc_im, sh_re, sh_im;
    logic [AW+9:0]   idx_ext;

    r2fft_bfly_ctl_t               ctl;
    logic signed [TWIDDLE_WIDTH-1:0] tw_cos, tw_sin;
    logic [2*DW-1:0]               sum_data, dif_data;

    function automatic logic [31:0] to_out(input logic signed [DW-1:0] v);
        logic signed [XW-1:0] e;
        e = XW'(v);
        if (e > XW'(32'sh7fff_ffff)) e = XW'(32'sh7fff_ffff);
        else if (e < XW'(32'sh8000_0000)) e = XW'(32'sh8000_0000);
        return e[31:0];
    endfunction

    // frame length in use, size clamped to the supported range
    always_comb begin
        if (size_reg == 4'd0) cur_l = LW'(1);
        else if (int'(size_reg) > AW) cur_l = LW'(AW);
        else cur_l = LW'(size_reg);
    end

    assign n_cur     = (AW+1)'(1) << cur_l;
    assign n_frm     = (AW+1)'(1) << frame_l_reg;
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc     = s_tvalid && s_tready;
    assign load_done = ({1'b0, load_ptr_reg} + (AW+1)'(1)) >= n_cur;
    assign read_last = ({1'b0, read_ptr_reg} + (AW+1)'(1)) >= n_cur;
    assign cnt_last  = {1'b0, cnt_reg} == (n_frm - (AW+1)'(1));
    assign half_last = {1'b0, cnt_reg} == ((n_frm >> 1) - (AW+1)'(1));
    assign smp_re    = s_tdata[15:0];
    assign smp_im    = s_tdata[31:16];

    // bit-reversed counter within the frame
    always_comb begin
        for (int b = 0; b < AW; b++) rev_full[b] = cnt_reg[AW-1-b];
    end
    assign rev = rev_full >> (LW'(AW) - frame_l_reg);

    // butterfly addresses: insert a zero at bit stage-1 of the counter
    assign hm     = AW'(1) << (stage_reg - LW'(1));
    assign bf_j   = cnt_reg & (hm - AW'(1));
    assign bf_p   = ((cnt_reg >> (stage_reg - LW'(1))) << stage_reg) | bf_j;
    assign bf_q   = bf_p | hm;
    assign t_full = bf_j << (LW'(AW) - stage_reg);

    // inverse scaling: rounding arithmetic shift by log2(n)
    assign rnd   = (DW+1)'(1) <<< (frame_l_reg - LW'(1));
    assign sc_re = (DW+1)'($signed(rd_reg[DW-1:0])) + rnd;
    assign sc_im = (DW+1)'($signed(rd_reg[2*DW-1:DW])) + rnd;
    assign sh_re = sc_re >>> frame_l_reg;
    assign sh_im = sc_im >>> frame_l_reg;

    r2fft_twiddle_rom #(
        .MAX_POINTS   (MAX_POINTS),
        .TWIDDLE_WIDTH(TWIDDLE_WIDTH)
    ) u_rom (
        .aclk  (aclk),
        .t_idx (t_full[TIW-1:0]),
        .tw_cos(tw_cos),
        .tw_sin(tw_sin)
    );

    r2fft_bfly_unit #(
        .DATA_WIDTH   (DATA_WIDTH),
        .TWIDDLE_WIDTH(TWIDDLE_WIDTH)
    ) u_bfly (
        .aclk    (aclk),
        .ctl     (ctl),
        .rd_data (rd_reg),
        .tw_cos  (tw_cos),
        .tw_sin  (tw_sin),
        .sum_data(sum_data),
        .dif_data(dif_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == ACT_LOAD && load_done) state_next = ST_SW_RDI;
                else if (s_acc && s_tuser == ACT_READ && frame_ready_reg) state_next = ST_READ;
            end
            ST_READ:   state_next = ST_IDLE;
            ST_SW_RDI: begin
                if (cnt_reg < rev) state_next = ST_SW_RDR;
                else if (cnt_last) state_next = ST_BF_RDQ;
            end
            ST_SW_RDR: state_next = ST_SW_WI;
            ST_SW_WI:  state_next = ST_SW_WR;
            ST_SW_WR:  state_next = cnt_last ? ST_BF_RDQ : ST_SW_RDI;
            ST_BF_RDQ: state_next = ST_BF_RDP;
            ST_BF_RDP: state_next = ST_BF_M0;
            ST_BF_M0:  state_next = ST_BF_M1;
            ST_BF_M1:  state_next = ST_BF_M2;
            ST_BF_M2:  state_next = ST_BF_M3;
            ST_BF_M3:  state_next = ST_BF_VI;
            ST_BF_VI:  state_next = ST_BF_WP;
            ST_BF_WP:  state_next = ST_BF_WQ;
            ST_BF_WQ: begin
                if (half_last && stage_reg == frame_l_reg)
                    state_next = inv_frame_reg ? ST_SC_RD : ST_IDLE;
                else state_next = ST_BF_RDQ;
            end
            ST_SC_RD:  state_next = ST_SC_WR;
            ST_SC_WR:  state_next = cnt_last ? ST_IDLE : ST_SC_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory ports and butterfly controls
    always_comb begin
        mem_we = 1'b0;
        waddr  = cnt_reg;
        wdata  = rd_reg;
        raddr  = cnt_reg;
        ctl    = '0;
        ctl.inv = inv_frame_reg;
        case (state_reg)
            ST_IDLE: begin
                raddr = read_ptr_reg;
                if (s_acc && s_tuser == ACT_LOAD) begin
                    mem_we = 1'b1;
                    waddr  = load_ptr_reg;
                    wdata  = {DW'(smp_im), DW'(smp_re)};
                end
            end
            ST_SW_RDR: raddr = rev;
            ST_SW_WI: begin
                mem_we = 1'b1;
                wdata  = rd_reg;
            end
            ST_SW_WR: begin
                mem_we = 1'b1;
                waddr  = rev;
                wdata  = hold_reg;
            end
            ST_BF_RDQ: raddr = bf_q;
            ST_BF_RDP: begin
                raddr    = bf_p;
                ctl.ld_x = 1'b1;
            end
            ST_BF_M0: begin
                ctl.ld_u    = 1'b1;
                ctl.mul_sel = MUL_RR;
            end
            ST_BF_M1: begin
                ctl.mul_sel = MUL_II;
                ctl.ld_pa   = 1'b1;
            end
            ST_BF_M2: begin
                ctl.mul_sel = MUL_RI;
                ctl.ld_vr   = 1'b1;
            end
            ST_BF_M3: begin
                ctl.mul_sel = MUL_IR;
                ctl.ld_pa   = 1'b1;
            end
            ST_BF_VI: ctl.ld_vi = 1'b1;
            ST_BF_WP: begin
                mem_we = 1'b1;
                waddr  = bf_p;
                wdata  = sum_data;
            end
            ST_BF_WQ: begin
                mem_we = 1'b1;
                waddr  = bf_q;
                wdata  = dif_data;
            end
            ST_SC_WR: begin
                mem_we = 1'b1;
                wdata  = {sh_im[DW-1:0], sh_re[DW-1:0]};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // pointers, counters and frame flags
    always_comb begin
        cnt_next         = cnt_reg;
        stage_next       = stage_reg;
        frame_l_next     = frame_l_reg;
        inv_frame_next   = inv_frame_reg;
        load_ptr_next    = load_ptr_reg;
        read_ptr_next    = read_ptr_reg;
        read_idx_next    = read_idx_reg;
        read_last_next   = read_last_reg;
        frame_ready_next = frame_ready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == ACT_LOAD) begin
                    frame_ready_next = 1'b0;
                    if (load_done) begin
                        load_ptr_next  = '0;
                        read_ptr_next  = '0;
                        frame_l_next   = cur_l;
                        inv_frame_next = inverse_reg;
                        cnt_next       = '0;
                    end else begin
                        load_ptr_next = load_ptr_reg + AW'(1);
                    end
                end else if (s_acc && frame_ready_reg) begin
                    read_idx_next  = read_ptr_reg;
                    read_last_next = read_last;
                    if (read_last) begin
                        read_ptr_next    = '0;
                        frame_ready_next = 1'b0;
                    end else begin
                        read_ptr_next = read_ptr_reg + AW'(1);
                    end
                end
            end
            ST_SW_RDI: begin
                if (!(cnt_reg < rev)) begin
                    cnt_next = cnt_last ? '0 : cnt_reg + AW'(1);
                    if (cnt_last) stage_next = LW'(1);
                end
            end
            ST_SW_WR: begin
                cnt_next = cnt_last ? '0 : cnt_reg + AW'(1);
                if (cnt_last) stage_next = LW'(1);
            end
            ST_BF_WQ: begin
                if (half_last) begin
                    cnt_next = '0;
                    if (stage_reg == frame_l_reg) frame_ready_next = !inv_frame_reg;
                    else stage_next = stage_reg + LW'(1);
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_SC_WR: begin
                if (cnt_last) frame_ready_next = 1'b1;
                else cnt_next = cnt_reg + AW'(1);
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            load_ptr_reg    <= '0;
            read_ptr_reg    <= '0;
            frame_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            inverse_reg     <= 1'b0;
            size_reg        <= 4'd10;
        end else begin
            state_reg       <= state_next;
            load_ptr_reg    <= load_ptr_next;
            read_ptr_reg    <= read_ptr_next;
            frame_ready_reg <= frame_ready_next;
            if (state_reg == ST_READ) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INVERSE: inverse_reg <= cfg_data[0];
                    REG_SIZE:    size_reg    <= cfg_data;
                    default:     inverse_reg <= inverse_reg;
                endcase
            end
        end
    end

    // payload and sequencing registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        stage_reg     <= stage_next;
        frame_l_reg   <= frame_l_next;
        inv_frame_reg <= inv_frame_next;
        read_idx_reg  <= read_idx_next;
        read_last_reg <= read_last_next;
        if (state_reg == ST_SW_RDR) hold_reg <= rd_reg;
        if (state_reg == ST_READ) begin
            out_re_reg   <= to_out(rd_reg[DW-1:0]);
            out_im_reg   <= to_out(rd_reg[2*DW-1:DW]);
            out_idx_reg  <= idx_ext[9:0];
            out_last_reg <= read_last_reg;
        end
    end

    assign idx_ext = (AW+10)'(read_idx_reg);

    // sample memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, out_idx_reg, out_im_reg, out_re_reg};
    assign m_tlast   = out_last_reg;

    // a fetched bin always lands in the result register
    a_read_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> m_tvalid)
        else $error("read fetch did not fill the result register");

    // no frame is offered while the transform is running
    a_no_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_READ) |-> !frame_ready_reg)
        else $error("frame flagged ready during transform");

    // butterfly stage stays within the frame
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BF_WQ) |-> (stage_reg != '0 && stage_reg <= frame_l_reg))
        else $error("butterfly stage out of range");

endmodule

>>> bench/fft_bin_checker.sv
// watches the request, result and configuration channels of the radix-2 fft engine,
// recomputes every bin in fixed point and compares; depends on r2fft_pkg
module fft_bin_checker
    import r2fft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          bins_pending,
    output int          bins_checked
);

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [9:0]         index;
        logic               last;
    } fft_bin_t;

    fft_bin_t    bins_due[$];
    longint      work_re[1024];
    longint      work_im[1024];
    longint      cos_rom[512];
    longint      sin_rom[512];
    logic [10:0] load_ptr;
    logic [10:0] read_ptr;
    logic        frame_done;
    logic        inv_mode;
    logic [3:0]  size_reg;

    function automatic longint rom_word(input int t, input bit want_cos);
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          sum;
        longint          r;
        bit              upper;
        upper = t > 256;
        u     = upper ? longint'(512 - t) : longint'(t);
        x     = (u * TWO_PI_Q30 + 512) / 1024;
        x2    = (x * x) >> 30;
        term  = want_cos ? Q30_ONE : x;
        sum   = longint'(term);
        for (int k = 1; k <= 12; k++) begin
            d    = want_cos ? longint'((2 * k - 1) * (2 * k)) : longint'((2 * k) * (2 * k + 1));
            term = ((term * x2) >> 30) / d;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        r = (sum + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        return (want_cos && upper) ? -r : r;
    endfunction

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint mul_q15(input longint x, input longint w);
        return (x * w + 64'sd16384) >>> 15;
    endfunction

    function automatic int frame_bits(input logic [3:0] sz);
        if (sz == 0) return 1;
        if (sz > 10) return 10;
        return int'(sz);
    endfunction

    task automatic transform_frame(input int lg, input bit inv);
        int     n;
        int     r;
        int     t;
        int     p;
        int     q;
        longint tmp;
        longint wr;
        longint wi;
        longint vr;
        longint vi;
        longint ur;
        longint ui;
        n = 1 << lg;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int b = 0; b < lg; b++)
                if (i[b]) r |= 1 << (lg - 1 - b);
            if (i < r) begin
                tmp = work_re[i]; work_re[i] = work_re[r]; work_re[r] = tmp;
                tmp = work_im[i]; work_im[i] = work_im[r]; work_im[r] = tmp;
            end
        end
        for (int len = 2; len <= n; len <<= 1) begin
            for (int i = 0; i < n; i += len) begin
                for (int j = 0; j < len / 2; j++) begin
                    t  = (j * (1024 / len)) & 511;
                    p  = i + j;
                    q  = p + len / 2;
                    wr = cos_rom[t];
                    wi = inv ? -sin_rom[t] : sin_rom[t];
                    vr = sat32(mul_q15(work_re[q], wr) - mul_q15(work_im[q], wi));
                    vi = sat32(mul_q15(work_re[q], wi) + mul_q15(work_im[q], wr));
                    ur = work_re[p];
                    ui = work_im[p];
                    work_re[p] = sat32(ur + vr);
                    work_im[p] = sat32(ui + vi);
                    work_re[q] = sat32(ur - vr);
                    work_im[q] = sat32(ui - vi);
                end
            end
        end
        if (inv) begin
            for (int i = 0; i < n; i++) begin
                work_re[i] = (work_re[i] + (64'sd1 <<< (lg - 1))) >>> lg;
                work_im[i] = (work_im[i] + (64'sd1 <<< (lg - 1))) >>> lg;
            end
        end
    endtask

    initial begin
        for (int t = 0; t < 512; t++) begin
            cos_rom[t] = rom_word(t, 1'b1);
            sin_rom[t] = rom_word(t, 1'b0);
        end
    end

    assign bins_pending = bins_due.size();

    always @(posedge aclk) begin
        int       n;
        int       a;
        fft_bin_t b;
        fft_bin_t got;
        if (!aresetn) begin
            load_ptr     <= '0;
            read_ptr     <= '0;
            frame_done   <= 1'b0;
            inv_mode     <= 1'b0;
            size_reg     <= 4'd10;
            fail_count   = 0;
            bins_checked = 0;
            bins_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_INVERSE) inv_mode <= cfg_data[0];
                else size_reg <= cfg_data;
            end
            n = 1 << frame_bits(size_reg);
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_LOAD) begin
                    a = int'(load_ptr[9:0]);
                    work_re[a] = longint'($signed(s_tdata[15:0]));
                    work_im[a] = longint'($signed(s_tdata[31:16]));
                    if (a + 1 >= n) begin
                        transform_frame(frame_bits(size_reg), inv_mode);
                        load_ptr   <= '0;
                        read_ptr   <= '0;
                        frame_done <= 1'b1;
                    end else begin
                        load_ptr   <= {1'b0, load_ptr[9:0] + 10'd1};
                        frame_done <= 1'b0;
                    end
                end else if (frame_done) begin
                    a       = int'(read_ptr[9:0]);
                    b.re    = work_re[a][31:0];
                    b.im    = work_im[a][31:0];
                    b.index = a[9:0];
                    b.last  = a + 1 >= n;
                    bins_due.push_back(b);
                    if (b.last) begin
                        read_ptr   <= '0;
                        frame_done <= 1'b0;
                    end else begin
                        read_ptr <= 11'(a + 1);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.re    = m_tdata[31:0];
                got.im    = m_tdata[63:32];
                got.index = m_tdata[73:64];
                got.last  = m_tlast;
                if (bins_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected bin: re %0d im %0d index %0d last %0b",
                                 got.re, got.im, got.index, got.last);
                end else begin
                    b = bins_due.pop_front();
                    bins_checked++;
                    if (got.re !== b.re || got.im !== b.im || got.index !== b.index
                        || got.last !== b.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("bin mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                     b.re, b.im, b.index, b.last,
                                     got.re, got.im, got.index, got.last);
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb.sv
// stimulus and verdict for the radix-2 fft engine: frames of loads and reads
// under random idling; depends on r2fft_pkg, radix2_fft_engine_top, fft_bin_checker
module tb;
    import r2fft_pkg::*;

    localparam int IDLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    int fail_count;
    int bins_pending;
    int bins_checked;
    int requests_sent;
    int frames_loaded;
    int hold_request;   // long receiver hold-off, asked by the stimulus
    bit tx_steady;      // stretches with no sender gaps
    bit rx_steady;      // stretches with no receiver stalls
    int cur_bits;       // effective log2 frame length of the current size setting
    int busy_bits;      // size of the last frame loaded, for the settle time

    radix2_fft_engine_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fft_bin_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .bins_pending (bins_pending),
        .bins_checked (bins_checked)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: cycles in a row with no accepted request, result or write
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout: no progress for %0d cycles", idle);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random stall before each result, plus an occasional long hold-off
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // one request on the input channel, with a random gap in front;
    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(input logic act, input logic [15:0] re, input logic [15:0] im);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {im, re};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        // valid stays up; the next request or settle takes it down
        @(negedge aclk);
    endtask

    // load kinds: 0 random, 1 alternating full scale, 2 impulse
    task automatic load_samples(input int count, input int kind);
        logic [15:0] re;
        logic [15:0] im;
        for (int i = 0; i < count; i++) begin
            case (kind)
                1: begin
                    re = i[0] ? 16'h8000 : 16'h7fff;
                    im = i[0] ? 16'h7fff : 16'h8000;
                end
                2: begin
                    re = (i == 0) ? 16'h7fff : 16'h0000;
                    im = 16'h0000;
                end
                default: begin
                    re = 16'($urandom);
                    im = 16'($urandom);
                end
            endcase
            send(ACT_LOAD, re, im);
        end
    endtask

    task automatic read_bins(input int count);
        for (int i = 0; i < count; i++) send(ACT_READ, 16'($urandom), 16'($urandom));
    endtask

    // full frame at the current size
    task automatic load_frame(input int kind);
        load_samples(1 << cur_bits, kind);
        busy_bits = cur_bits;
        frames_loaded++;
    endtask

    // wait until no bin is owed, then long enough for a transform to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (bins_pending != 0) @(negedge aclk);
        repeat (5 * (1 << busy_bits) * busy_bits + 4 * (1 << busy_bits) + 64) @(negedge aclk);
        busy_bits = 1;
    endtask

    // register write, only issued while the engine is idle
    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_SIZE) cur_bits = (val == 0) ? 1 : (val > 10) ? 10 : int'(val);
    endtask

    initial begin
        int sz;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_LOAD;
        cfg_valid     = 1'b0;
        cfg_index     = REG_INVERSE;
        cfg_data      = '0;
        hold_request  = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        requests_sent = 0;
        frames_loaded = 0;
        cur_bits      = 10;
        busy_bits     = 1;
        aresetn       = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reads with no finished frame give nothing
        read_bins(2);
        settle();

        // size 0 behaves as two points, full scale samples
        write_reg(REG_INVERSE, 1'b0);
        write_reg(REG_SIZE, 4'd0);
        load_frame(1);
        read_bins(3);
        settle();

        // inverse with scaling on an impulse of four points
        write_reg(REG_INVERSE, 1'b1);
        write_reg(REG_SIZE, 4'd2);
        load_frame(2);
        read_bins(4);
        settle();

        // a load during readout drops the frame being read
        write_reg(REG_INVERSE, 1'b0);
        load_frame(0);
        read_bins(1);
        load_frame(1);
        read_bins(4);
        settle();

        // size shrinks mid-frame: the next load completes the smaller frame
        write_reg(REG_SIZE, 4'd3);
        load_samples(3, 0);
        settle();
        write_reg(REG_SIZE, 4'd1);
        load_samples(1, 0);
        busy_bits = 1;
        read_bins(2);
        settle();

        // largest size through an out of range value, partly read out
        write_reg(REG_SIZE, 4'd15);
        tx_steady = 1'b1;
        load_frame(0);
        tx_steady = 1'b0;
        read_bins(40);
        settle();
        write_reg(REG_SIZE, 4'd10);

        // long receiver hold-off while reads keep coming, so the engine backs up
        write_reg(REG_SIZE, 4'd5);
        load_frame(0);
        hold_request = 300;
        tx_steady    = 1'b1;
        read_bins(32);
        tx_steady = 1'b0;
        settle();

        // random frames: mostly small, both directions, varied readout
        while (requests_sent < 1850) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
            if (sz == 0 && $urandom_range(0, 1)) sz = $urandom_range(11, 15) == 15 ? 0 : 0;
            write_reg(REG_SIZE, 4'(sz));
            write_reg(REG_INVERSE, 1'($urandom_range(0, 1)));
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0) read_bins(1);
            load_frame(0);
            case ($urandom_range(0, 5))
                0: begin
                    // partial readout, then a fresh frame drops the rest
                    read_bins($urandom_range(1, 1 << cur_bits));
                    load_frame(0);
                    read_bins(1 << cur_bits);
                end
                1: read_bins((1 << cur_bits) + $urandom_range(1, 3));
                default: read_bins(1 << cur_bits);
            endcase
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            settle();
        end

        settle();
        repeat (100) @(negedge aclk);
        $display("covered %0d requests over %0d frames, %0d bins checked", requests_sent,
                 frames_loaded, bins_checked);
        $display("sizes 2 to 1024 points, forward and inverse, drops, shrink and back-pressure");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
